// ===== design/dda_line_stepper_macros.svh =====
// ----------------------------------------------------------------------------
// dda_line_stepper_macros
// assertion helpers for the line stepper
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_STEPPER_MACROS_SVH
`define DDA_LINE_STEPPER_MACROS_SVH

// same-cycle implication, checked out of reset
`define DDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dda_pkg.sv =====
// ----------------------------------------------------------------------------
// dda_pkg
// shared constants, state encoding and control structs of the line stepper
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // item mode codes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // start word taken
    logic step;      // step word taken
    logic setup;     // magnitudes and step count
    logic prep;      // load dividers
    logic div_step;  // one quotient bit
    logic emit;      // publish start point, arm line
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
    logic zero_len;
  } sts_t;

endpackage

// ===== design/dda_ifs.sv =====
// ----------------------------------------------------------------------------
// dda_in_if / dda_out_if
// valid/ready channels carrying line commands and emitted points
// ----------------------------------------------------------------------------
interface dda_in_if import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic signed [COORD_BITS-1:0] depth_first;
  logic signed [COORD_BITS-1:0] depth_rest;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, depth_first, depth_rest,
    input  ready
  );
  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, depth_first, depth_rest,
    output ready
  );
endinterface

interface dda_out_if import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         point_valid;
  logic                         last_point;

  modport source (
    output valid, point_x, point_y, point_z, point_valid, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, point_valid, last_point,
    output ready
  );
endinterface

// ===== design/dda_ctrl.sv =====
// ----------------------------------------------------------------------------
// dda_ctrl
// sequencer for line setup and the increment division
// ----------------------------------------------------------------------------
module dda_ctrl import dda_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_mode,
  output logic in_ready,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

  state_t           state, state_next;
  logic [CNT_W-1:0] div_cnt;
  logic             accept;

  assign in_ready = (state == ST_IDLE) && (!sts.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && in_mode == MODE_START) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_PREP;
      ST_PREP:  state_next = sts.zero_len ? ST_EMIT : ST_DIV;
      ST_DIV:   if (div_cnt == CNT_LAST) state_next = ST_EMIT;
      ST_EMIT:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = accept && (in_mode == MODE_START);
        cmd.step    = accept && (in_mode == MODE_STEP);
      end
      ST_SETUP: cmd.setup    = 1'b1;
      ST_PREP:  cmd.prep     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_EMIT:  cmd.emit     = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PREP) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

endmodule

// ===== design/dda_datapath.sv =====
// ----------------------------------------------------------------------------
// dda_datapath
// line setup, two restoring dividers, accumulators and the output register
// ----------------------------------------------------------------------------
module dda_datapath import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  input  logic signed [COORD_BITS-1:0] depth_first,
  input  logic signed [COORD_BITS-1:0] depth_rest,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic                         point_valid,
  output logic                         last_point
);

  localparam int CW = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = CW + 1;       // differences, magnitudes, step count
  localparam int NW = CW + F + 2;   // scaled dividend
  localparam int QW = F + 1;        // quotient, at most 1.0
  localparam int SW = F + 2;        // signed increment
  localparam int AW = CW + F + 1;   // accumulator
  localparam logic signed [AW:0] HALF = (AW+1)'(1) <<< (F - 1);

  // captured start word
  logic signed [CW-1:0] xs, ys, depth0, later_depth;
  logic signed [DW-1:0] dx, dy;
  // setup results
  logic [DW-1:0] mag_x, mag_y, steps;
  logic          neg_x, neg_y;
  // dividers
  logic [DW-1:0] rem_x, rem_y;
  logic [QW-1:0] q_x, q_y;
  // line state
  logic signed [SW-1:0] x_step, y_step;
  logic signed [AW-1:0] x_accum, y_accum;
  logic [DW-1:0]        steps_left;
  logic                 line_busy;

  logic [DW-1:0]        ax, ay;
  logic [NW-1:0]        num_x, num_y;
  logic [DW:0]          trial_x, trial_y;
  logic                 ge_x, ge_y;
  logic signed [AW-1:0] x_sum, y_sum;
  logic signed [AW:0]   x_rnd, y_rnd;

  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // scaled magnitude plus half of the divisor, rounds the quotient to nearest
  assign num_x = {1'b0, mag_x, {F{1'b0}}} + NW'(steps >> 1);
  assign num_y = {1'b0, mag_y, {F{1'b0}}} + NW'(steps >> 1);

  assign trial_x = {rem_x, q_x[QW-1]};
  assign trial_y = {rem_y, q_y[QW-1]};
  assign ge_x    = trial_x >= {1'b0, steps};
  assign ge_y    = trial_y >= {1'b0, steps};

  // next position and its rounding, ties away from zero
  assign x_sum = x_accum + AW'(x_step);
  assign y_sum = y_accum + AW'(y_step);
  assign x_rnd = (AW+1)'(x_sum) + HALF - (AW+1)'(x_sum[AW-1]);
  assign y_rnd = (AW+1)'(y_sum) + HALF - (AW+1)'(y_sum[AW-1]);

  assign sts.out_valid = out_valid;
  assign sts.zero_len  = (steps == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs          <= x_start;
      ys          <= y_start;
      dx          <= DW'(x_end) - DW'(x_start);
      dy          <= DW'(y_end) - DW'(y_start);
      depth0      <= depth_first;
      later_depth <= depth_rest;
    end
    if (cmd.setup) begin
      mag_x <= ax;
      mag_y <= ay;
      neg_x <= dx[DW-1];
      neg_y <= dy[DW-1];
      steps <= (ax > ay) ? ax : ay;
    end
    if (cmd.prep) begin
      rem_x <= num_x[NW-1:QW];
      rem_y <= num_y[NW-1:QW];
      q_x   <= num_x[QW-1:0];
      q_y   <= num_y[QW-1:0];
    end
    if (cmd.div_step) begin
      rem_x <= ge_x ? DW'(trial_x - {1'b0, steps}) : trial_x[DW-1:0];
      rem_y <= ge_y ? DW'(trial_y - {1'b0, steps}) : trial_y[DW-1:0];
      q_x   <= {q_x[QW-2:0], ge_x};
      q_y   <= {q_y[QW-2:0], ge_y};
    end
    if (cmd.emit) begin
      x_step      <= neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
      y_step      <= neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
      x_accum     <= AW'(xs) <<< F;
      y_accum     <= AW'(ys) <<< F;
      point_x     <= xs;
      point_y     <= ys;
      point_z     <= depth0;
      point_valid <= 1'b1;
      last_point  <= (steps == '0);
    end
    if (cmd.step) begin
      if (line_busy) begin
        x_accum     <= x_sum;
        y_accum     <= y_sum;
        point_x     <= x_rnd[F+CW-1:F];
        point_y     <= y_rnd[F+CW-1:F];
        point_z     <= later_depth;
        point_valid <= 1'b1;
        last_point  <= (steps_left == DW'(1));
      end else begin
        point_x     <= '0;
        point_y     <= '0;
        point_z     <= '0;
        point_valid <= 1'b0;
        last_point  <= 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      line_busy  <= 1'b0;
      steps_left <= '0;
    end else begin
      if (cmd.emit || cmd.step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        steps_left <= steps;
        line_busy  <= (steps != '0);
      end else if (cmd.step && line_busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == DW'(1)) begin
          line_busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/dda_line_stepper.sv =====
// ----------------------------------------------------------------------------
// dda_line_stepper
// dda line stepper: start a line from two endpoints, then step along it
// ----------------------------------------------------------------------------
// usage
//   item  : command words; mode start carries both endpoints and two depths,
//           mode step asks for the next point of the current line
//   point : one word per command; start gives the start point with
//           depth_first, each step the next rounded point with depth_rest,
//           last_point marks the end; a step with no line gives point_valid 0
// timing
//   step word  : the point is registered on the accepting edge;
//                steps sustain one word per cycle while points are taken
//   start word : two restoring dividers form the per-step increments one
//                quotient bit per cycle; item ready stays low while the
//                line is set up; a zero-length line skips the division
// reset
//   synchronous rst returns to idle with no line armed and no point pending
// stalls
//   the output register holds a point until taken; a new word is taken in the
//   same cycle that the pending point drains
// ----------------------------------------------------------------------------
`include "dda_line_stepper_macros.svh"

module dda_line_stepper import dda_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  dda_in_if.sink   item,
  dda_out_if.source point
);

  cmd_t cmd;
  sts_t sts;

  // handshake terms for the checks below
  logic slot_free, start_take, step_take, setup_busy, no_take;

  // sequencer: accept gating and the division count
  dda_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_mode   (item.mode),
    .in_ready  (item.ready),
    .out_ready (point.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and the output register
  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .x_start     (item.x_start),
    .y_start     (item.y_start),
    .x_end       (item.x_end),
    .y_end       (item.y_end),
    .depth_first (item.depth_first),
    .depth_rest  (item.depth_rest),
    .out_ready   (point.ready),
    .out_valid   (point.valid),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_z     (point.point_z),
    .point_valid (point.point_valid),
    .last_point  (point.last_point)
  );

  assign slot_free  = !point.valid || point.ready;
  assign start_take = item.valid && item.ready && (item.mode == MODE_START);
  assign step_take  = item.valid && item.ready && (item.mode == MODE_STEP);
  assign setup_busy = cmd.setup || cmd.prep || cmd.div_step;
  assign no_take    = !item.ready && !cmd.step;

  // a word is only taken when the output slot is free or draining
  `DDA_ASSERT_NOW(a_ready_slot, clk, rst, item.ready, slot_free, "ready with a stalled point")
  // a start word never shows its point before the division finishes
  `DDA_ASSERT_NEXT(a_start_waits, clk, rst, start_take, !point.valid, "start point too early")
  // a step word answers on the next cycle
  `DDA_ASSERT_NEXT(a_step_answers, clk, rst, step_take, point.valid, "step word without a point")
  // no line activity while a start is being set up
  `DDA_ASSERT_NOW(a_setup_quiet, clk, rst, setup_busy, no_take, "word taken during setup")

endmodule

// ===== bench/dda_line_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// dda_line_stepper_tb
// self-checking bench for the dda line stepper: a queue-fed driver sends
// start and step words, a predictor tracks the line state to form the
// expected point for each accepted word, and a monitor checks every point
// word as it is taken, under two patterns of random idling and one with none
// ----------------------------------------------------------------------------
module dda_line_stepper_tb;
  import dda_pkg::*;

  localparam int COORD_BITS = COORD_BITS_DEF;
  localparam int FRAC_BITS  = FRAC_BITS_DEF;

  // fixed point one and one half at the block's fraction width
  localparam longint FIX_ONE  = 64'sd1 <<< FRAC_BITS;
  localparam longint FIX_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  // coordinate range of a field
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one command word as the sender sees it
  typedef struct {
    logic   mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    coord_t depth_first;
    coord_t depth_rest;
  } line_cmd_t;

  // one point word as the receiver sees it
  typedef struct {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   point_valid;
    logic   last_point;
  } point_word_t;

  logic clk = 1'b0;
  logic rst;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) item_if ();
  dda_out_if #(.COORD_BITS(COORD_BITS)) point_if ();

  dda_line_stepper #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_if),
    .point(point_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // words waiting to be sent, and points still owed by the block
  line_cmd_t   pending_words[$];
  point_word_t expected_points[$];
  line_cmd_t   word_on_bus;

  int send_idle_pct;
  int recv_idle_pct;
  bit send_hold;
  int mismatches;
  int words_queued;

  // ---------------------------------------------------------------------------
  // line tracking state, mirrors what the block must hold between words
  // ---------------------------------------------------------------------------
  longint pos_x, pos_y;      // position, FRAC_BITS fraction bits
  longint inc_x, inc_y;      // per-step increments, same format
  longint steps_remaining;
  coord_t stored_depth;
  bit     drawing;

  // nearest integer, halves go away from zero
  function automatic longint round_away(longint a);
    if (a >= 0) begin
      return (a + FIX_HALF) / FIX_ONE;
    end
    return -((-a + FIX_HALF) / FIX_ONE);
  endfunction

  // d / n in fixed point, magnitude rounded to nearest with ties up, sign of d
  function automatic longint fixed_increment(longint d, longint n);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q   = (mag * FIX_ONE + n / 2) / n;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint line_length(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    longint ax, ay;
    ax = longint'(xe) - longint'(xs);
    ay = longint'(ye) - longint'(ys);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    return (ax > ay) ? ax : ay;
  endfunction

  // advance the tracking state by one accepted word, return the owed point
  function automatic point_word_t predict_point(line_cmd_t c);
    point_word_t p;
    longint      n;
    p = '{point_x: '0, point_y: '0, point_z: '0, point_valid: 1'b0, last_point: 1'b0};
    if (c.mode == MODE_START) begin
      n            = line_length(c.x_start, c.y_start, c.x_end, c.y_end);
      pos_x        = longint'(c.x_start) * FIX_ONE;
      pos_y        = longint'(c.y_start) * FIX_ONE;
      stored_depth = c.depth_rest;
      if (n == 0) begin
        // zero-length line: start point alone, marked last
        inc_x           = 0;
        inc_y           = 0;
        steps_remaining = 0;
        drawing         = 1'b0;
      end else begin
        // also abandons any line still in progress
        inc_x           = fixed_increment(longint'(c.x_end) - longint'(c.x_start), n);
        inc_y           = fixed_increment(longint'(c.y_end) - longint'(c.y_start), n);
        steps_remaining = n;
        drawing         = 1'b1;
      end
      p.point_x     = c.x_start;
      p.point_y     = c.y_start;
      p.point_z     = c.depth_first;
      p.point_valid = 1'b1;
      p.last_point  = (n == 0);
    end else if (drawing) begin
      pos_x           = pos_x + inc_x;
      pos_y           = pos_y + inc_y;
      steps_remaining = steps_remaining - 1;
      p.point_x       = coord_t'(round_away(pos_x));
      p.point_y       = coord_t'(round_away(pos_y));
      p.point_z       = stored_depth;
      p.point_valid   = 1'b1;
      p.last_point    = (steps_remaining == 0);
      if (steps_remaining == 0) drawing = 1'b0;
    end
    // a step with no line leaves every field at zero
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: a word leaves the queue once the previous one has been taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      // the word on the bus was taken at this edge
      if (item_if.valid && item_if.ready) begin
        expected_points.push_back(predict_point(word_on_bus));
      end
      if (!item_if.valid || item_if.ready) begin
        if (pending_words.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          word_on_bus          = pending_words.pop_front();
          item_if.mode        <= word_on_bus.mode;
          item_if.x_start     <= word_on_bus.x_start;
          item_if.y_start     <= word_on_bus.y_start;
          item_if.x_end       <= word_on_bus.x_end;
          item_if.y_end       <= word_on_bus.y_end;
          item_if.depth_first <= word_on_bus.depth_first;
          item_if.depth_rest  <= word_on_bus.depth_rest;
          item_if.valid       <= 1'b1;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every taken point is checked against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_word_t exp_pt;
    if (rst) begin
      point_if.ready <= 1'b0;
    end else begin
      if (point_if.valid && point_if.ready) begin
        if (expected_points.size() == 0) begin
          $error("point word with nothing owed: x %0d y %0d z %0d",
                 point_if.point_x, point_if.point_y, point_if.point_z);
          mismatches++;
        end else begin
          exp_pt = expected_points.pop_front();
          if (point_if.point_x !== exp_pt.point_x) begin
            $error("point_x: expected %0d, got %0d", exp_pt.point_x, point_if.point_x);
            mismatches++;
          end
          if (point_if.point_y !== exp_pt.point_y) begin
            $error("point_y: expected %0d, got %0d", exp_pt.point_y, point_if.point_y);
            mismatches++;
          end
          if (point_if.point_z !== exp_pt.point_z) begin
            $error("point_z: expected %0d, got %0d", exp_pt.point_z, point_if.point_z);
            mismatches++;
          end
          if (point_if.point_valid !== exp_pt.point_valid) begin
            $error("point_valid: expected %0b, got %0b",
                   exp_pt.point_valid, point_if.point_valid);
            mismatches++;
          end
          if (point_if.last_point !== exp_pt.last_point) begin
            $error("last_point: expected %0b, got %0b",
                   exp_pt.last_point, point_if.last_point);
            mismatches++;
          end
        end
      end
      point_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // step word; its coordinate and depth fields must be ignored, so fill them
  task automatic queue_step();
    line_cmd_t c;
    c.mode        = MODE_STEP;
    c.x_start     = coord_t'($urandom);
    c.y_start     = coord_t'($urandom);
    c.x_end       = coord_t'($urandom);
    c.y_end       = coord_t'($urandom);
    c.depth_first = coord_t'($urandom);
    c.depth_rest  = coord_t'($urandom);
    pending_words.push_back(c);
    words_queued++;
  endtask

  // start word followed by a number of step words
  task automatic queue_line(int xs, int ys, int xe, int ye, int zf, int zr, longint n_steps);
    line_cmd_t c;
    c.mode        = MODE_START;
    c.x_start     = coord_t'(xs);
    c.y_start     = coord_t'(ys);
    c.x_end       = coord_t'(xe);
    c.y_end       = coord_t'(ye);
    c.depth_first = coord_t'(zf);
    c.depth_rest  = coord_t'(zr);
    pending_words.push_back(c);
    words_queued++;
    for (longint i = 0; i < n_steps; i++) queue_step();
  endtask

  // endpoint a short distance away, folded back when it would leave the range
  function automatic int near_end(int s, int reach);
    int d;
    d = $urandom_range(reach);
    if ($urandom_range(1)) d = -d;
    if (s + d > COORD_MAX || s + d < COORD_MIN) return s - d;
    return s + d;
  endfunction

  task automatic queue_random_words(int target);
    int xs, ys, xe, ye, reach, kind;
    longint n;
    line_cmd_t c;
    words_queued = 0;
    while (words_queued < target) begin
      kind  = $urandom_range(99);
      reach = ($urandom_range(19) == 0) ? 300 : 12;
      xs    = int'(coord_t'($urandom));
      ys    = int'(coord_t'($urandom));
      if (kind < 80) begin
        xe = near_end(xs, reach);
        ye = near_end(ys, ($urandom_range(3) == 0) ? 0 : reach);
      end else begin
        // any endpoints at all; such lines usually get cut short
        xe = int'(coord_t'($urandom));
        ye = int'(coord_t'($urandom));
      end
      n = line_length(coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye));
      if (kind < 70) begin
        // complete line
        queue_line(xs, ys, xe, ye, int'(coord_t'($urandom)), int'(coord_t'($urandom)), n);
      end else if (kind < 78) begin
        // complete line, then steps past its end
        queue_line(xs, ys, xe, ye, int'(coord_t'($urandom)), int'(coord_t'($urandom)), n);
        repeat ($urandom_range(1, 3)) queue_step();
      end else if (kind < 90) begin
        // line cut off by the next start
        queue_line(xs, ys, xe, ye, int'(coord_t'($urandom)), int'(coord_t'($urandom)),
                   (n == 0) ? 0 : $urandom_range(0, (n > 8) ? 8 : n - 1));
      end else begin
        // noise: a lone word of either kind with random fields
        c.mode        = 1'($urandom_range(1));
        c.x_start     = coord_t'($urandom);
        c.y_start     = coord_t'($urandom);
        c.x_end       = coord_t'($urandom);
        c.y_end       = coord_t'($urandom);
        c.depth_first = coord_t'($urandom);
        c.depth_rest  = coord_t'($urandom);
        pending_words.push_back(c);
        words_queued++;
      end
    end
  endtask

  // block until every queued word is sent and every owed point has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || item_if.valid || expected_points.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    rst                  = 1'b1;
    item_if.valid        = 1'b0;
    item_if.mode         = MODE_START;
    item_if.x_start      = '0;
    item_if.y_start      = '0;
    item_if.x_end        = '0;
    item_if.y_end        = '0;
    item_if.depth_first  = '0;
    item_if.depth_rest   = '0;
    point_if.ready       = 1'b0;
    send_idle_pct        = 38;
    recv_idle_pct        = 59;
    send_hold            = 1'b0;
    mismatches           = 0;
    drawing              = 1'b0;
    pos_x                = 0;
    pos_y                = 0;
    inc_x                = 0;
    inc_y                = 0;
    steps_remaining      = 0;
    stored_depth         = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words
    // step straight out of reset, no line armed
    queue_step();
    // zero-length line at the corner, depth extremes, then a step with no line
    queue_line(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0);
    queue_step();
    // quarter slopes hit exact halves, rounded away from zero both ways
    queue_line(0, 0, 4, 1, 7, -7, 4);
    queue_line(0, 0, -4, -1, -1, 1, 4);
    // thirds need rounding of the increment itself
    queue_line(0, 0, 3, 2, 0, COORD_MIN, 3);
    // full diagonal, abandoned by a steep line, itself abandoned
    queue_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 0, 2);
    queue_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MIN, 3, COORD_MIN, 2);
    // unit line, then one step too many
    queue_line(5, -7, 6, -7, -3, 4, 1);
    queue_step();

    // sender idles less than receiver
    queue_random_words(180);
    wait_drained();

    // roles swapped, with one pause until every owed point is home
    send_idle_pct = 59;
    recv_idle_pct = 38;
    queue_random_words(180);
    do @(negedge clk); while (pending_words.size() > 90);
    send_hold = 1'b1;
    do @(negedge clk); while (item_if.valid || expected_points.size() != 0);
    send_hold = 1'b0;
    wait_drained();

    // no idling, then a line across the whole range, left after 64 steps
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_words(180);
    queue_line(COORD_MIN, COORD_MAX, COORD_MAX, -1000, 11, -11, 64);
    wait_drained();

    // room for a late stray word before the final verdict
    repeat (FRAC_BITS + 15) @(negedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("dda_line_stepper_tb: clean");
    end else begin
      $display("dda_line_stepper_tb: errors");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("dda_line_stepper_tb: errors");
    $finish;
  end

endmodule
